FILE: design/lsa_pkg.sv
// Package for the LRU slot allocator: field widths, operation and status codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package lsa_pkg;

	localparam int KEY_W  = 64;
	localparam int TICK_W = 48;
	localparam int KIND_W = 3;
	localparam int STAT_W = 3;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	localparam logic [KIND_W-1:0] KIND_LOOKUP    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_TOUCH     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PIN_CLEAR = 3'd4;
	localparam logic [KIND_W-1:0] KIND_PIN_ADD   = 3'd5;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NOT_FOUND = 3'd1,
		STAT_NO_ROOM   = 3'd2,
		STAT_READ_ONLY = 3'd3,
		STAT_PIN_FULL  = 3'd4
	} status_t;

	typedef struct packed {
		logic    load;
		logic    slot_rst;
		logic    slot_inc;
		logic    find_cmp;
		logic    pin_rst;
		logic    pin_inc;
		logic    pin_cmp_slot;
		logic    pin_cmp_key;
		logic    cand_eval;
		logic    mark_hit;
		logic    write_entry;
		logic    use_best;
		logic    touch;
		logic    remove;
		logic    pins_clear;
		logic    pin_write;
		logic    set_status;
		status_t res_status;
		logic    set_result;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              read_only;
		logic              found;
		logic              free_found;
		logic              best_found;
		logic              pinned;
		logic              pin_free_found;
		logic              slot_last;
		logic              pin_last;
		logic              out_busy;
	} dp_stat_t;

endpackage

FILE: design/lsa_if.sv
// Request and response channel interfaces of the LRU slot allocator.
// Depends on lsa_pkg.
interface lsa_req_if;
	import lsa_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	modport source (output valid, output kind, output key, input ready);
	modport sink (input valid, input kind, input key, output ready);
endinterface

interface lsa_rsp_if #(parameter int SLOT_W = 6);
	import lsa_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              evicted;
	logic [KEY_W-1:0]  evicted_key;
	modport source (output valid, output status, output hit, output slot, output evicted,
		output evicted_key, input ready);
	modport sink (input valid, input status, input hit, input slot, input evicted,
		input evicted_key, output ready);
endinterface

FILE: design/lsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: design/lsa_ctrl.sv
// Controller state machine of the LRU slot allocator: sequences the slot and pin
// scans and issues commands to the datapath. Depends on lsa_pkg.
module lsa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  lsa_pkg::dp_stat_t stat,
	output lsa_pkg::dp_cmd_t  cmd
);
	import lsa_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE     = 14'h0001,
		S_DISPATCH = 14'h0002,
		S_F_RD     = 14'h0004,
		S_F_CMP    = 14'h0008,
		S_F_END    = 14'h0010,
		S_E_RD     = 14'h0020,
		S_E_PRD    = 14'h0040,
		S_E_PCMP   = 14'h0080,
		S_E_EVAL   = 14'h0100,
		S_E_END    = 14'h0200,
		S_P_RD     = 14'h0400,
		S_P_CMP    = 14'h0800,
		S_P_END    = 14'h1000,
		S_FIN      = 14'h2000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.res_status = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (stat.kind inside {KIND_LOOKUP, KIND_TOUCH}) begin
					state_d = S_F_RD;
				end else if (stat.kind inside {KIND_INSERT, KIND_REMOVE}) begin
					if (stat.read_only) begin
						cmd.set_status = 1'b1;
						cmd.res_status = STAT_READ_ONLY;
						state_d = S_FIN;
					end else begin
						state_d = S_F_RD;
					end
				end else if (stat.kind == KIND_PIN_CLEAR) begin
					cmd.pins_clear = 1'b1;
					state_d = S_FIN;
				end else if (stat.kind == KIND_PIN_ADD) begin
					state_d = S_P_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_F_RD: state_d = S_F_CMP;
			S_F_CMP: begin
				cmd.find_cmp = 1'b1;
				if (stat.slot_last) begin
					state_d = S_F_END;
				end else begin
					cmd.slot_inc = 1'b1;
					state_d = S_F_RD;
				end
			end
			S_F_END: begin
				state_d = S_FIN;
				if (stat.found) begin
					cmd.mark_hit = 1'b1;
					cmd.touch = (stat.kind == KIND_TOUCH);
					cmd.remove = (stat.kind == KIND_REMOVE);
				end else if (stat.kind != KIND_INSERT) begin
					cmd.set_status = 1'b1;
					cmd.res_status = STAT_NOT_FOUND;
				end else if (stat.free_found) begin
					cmd.write_entry = 1'b1;
				end else begin
					cmd.slot_rst = 1'b1;
					state_d = S_E_RD;
				end
			end
			S_E_RD: begin
				cmd.pin_rst = 1'b1;
				state_d = S_E_PRD;
			end
			S_E_PRD: state_d = S_E_PCMP;
			S_E_PCMP: begin
				cmd.pin_cmp_slot = 1'b1;
				if (stat.pin_last) begin
					state_d = S_E_EVAL;
				end else begin
					cmd.pin_inc = 1'b1;
					state_d = S_E_PRD;
				end
			end
			S_E_EVAL: begin
				cmd.cand_eval = 1'b1;
				if (stat.slot_last) begin
					state_d = S_E_END;
				end else begin
					cmd.slot_inc = 1'b1;
					state_d = S_E_RD;
				end
			end
			S_E_END: begin
				state_d = S_FIN;
				if (stat.best_found) begin
					cmd.write_entry = 1'b1;
					cmd.use_best = 1'b1;
				end else begin
					cmd.set_status = 1'b1;
					cmd.res_status = STAT_NO_ROOM;
				end
			end
			S_P_RD: state_d = S_P_CMP;
			S_P_CMP: begin
				cmd.pin_cmp_key = 1'b1;
				if (stat.pin_last) begin
					state_d = S_P_END;
				end else begin
					cmd.pin_inc = 1'b1;
					state_d = S_P_RD;
				end
			end
			S_P_END: begin
				state_d = S_FIN;
				if (!stat.pinned) begin
					if (stat.pin_free_found) begin
						cmd.pin_write = 1'b1;
					end else begin
						cmd.set_status = 1'b1;
						cmd.res_status = STAT_PIN_FULL;
					end
				end
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.set_result = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_DISPATCH)
		else $error("accepted item did not move to dispatch");
	a_fin_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !stat.out_busy |=> state_q == S_IDLE)
		else $error("result not released to idle");
	a_no_write_ro: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry || cmd.remove |-> !stat.read_only)
		else $error("table changed in read-only mode");
endmodule

FILE: design/lsa_dp.sv
// Datapath of the LRU slot allocator: slot and pin stores, scan counters,
// match and eviction trackers, tick and result register. Depends on lsa_pkg, lsa_ram.
module lsa_dp #(
	parameter int SLOTS = 64,
	parameter int PINS  = 16,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int PW = (PINS > 1) ? $clog2(PINS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lsa_pkg::dp_cmd_t              cmd,
	output lsa_pkg::dp_stat_t             stat,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic [lsa_pkg::KIND_W-1:0]   req_kind,
	input  logic [lsa_pkg::KEY_W-1:0]    req_key,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output logic [lsa_pkg::STAT_W-1:0]   rsp_status,
	output logic                         rsp_hit,
	output logic [SW-1:0]                rsp_slot,
	output logic                         rsp_evicted,
	output logic [lsa_pkg::KEY_W-1:0]    rsp_evicted_key
);
	import lsa_pkg::*;

	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic              read_only_q;
	logic [SLOTS-1:0]  valid_q;
	logic [PINS-1:0]   pin_valid_q;
	logic [TICK_W-1:0] tick_q, tick_nx;
	logic [SW-1:0]     si_q, found_slot_q, free_slot_q, best_slot_q, target_slot;
	logic [PW-1:0]     pj_q, pfree_idx_q;
	logic              found_q, free_found_q, best_found_q, pinned_q, pfree_found_q;
	logic [TICK_W-1:0] best_used_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [KEY_W-1:0]  key_rd, pin_rd;
	logic [TICK_W-1:0] used_rd;
	status_t           status_q;
	logic              res_hit_q, res_ev_q;
	logic [SW-1:0]     res_slot_q;
	logic [KEY_W-1:0]  res_evkey_q;
	logic              out_valid_q;

	assign target_slot = cmd.use_best ? best_slot_q : free_slot_q;
	assign tick_nx = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;

	lsa_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
		.clk(clk), .we(cmd.write_entry), .waddr(target_slot), .wdata(key_q),
		.raddr(si_q), .rdata(key_rd)
	);

	lsa_ram #(.WIDTH(TICK_W), .DEPTH(SLOTS)) u_used_ram (
		.clk(clk), .we(cmd.write_entry || cmd.touch),
		.waddr(cmd.touch ? found_slot_q : target_slot), .wdata(tick_nx),
		.raddr(si_q), .rdata(used_rd)
	);

	lsa_ram #(.WIDTH(KEY_W), .DEPTH(PINS)) u_pin_ram (
		.clk(clk), .we(cmd.pin_write), .waddr(pfree_idx_q), .wdata(key_q),
		.raddr(pj_q), .rdata(pin_rd)
	);

	always_comb begin
		stat.kind           = kind_q;
		stat.read_only      = read_only_q;
		stat.found          = found_q;
		stat.free_found     = free_found_q;
		stat.best_found     = best_found_q;
		stat.pinned         = pinned_q;
		stat.pin_free_found = pfree_found_q;
		stat.slot_last      = (si_q == SW'(SLOTS - 1));
		stat.pin_last       = (pj_q == PW'(PINS - 1));
		stat.out_busy       = out_valid_q && !rsp_ready;
	end

	// Control state: flags, valid bits, tick and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_only_q   <= 1'b0;
			valid_q       <= '0;
			pin_valid_q   <= '0;
			tick_q        <= '0;
			si_q          <= '0;
			pj_q          <= '0;
			found_q       <= 1'b0;
			free_found_q  <= 1'b0;
			best_found_q  <= 1'b0;
			pinned_q      <= 1'b0;
			pfree_found_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				read_only_q <= cfg_wdata;
			end
			if (cmd.load) begin
				si_q          <= '0;
				pj_q          <= '0;
				found_q       <= 1'b0;
				free_found_q  <= 1'b0;
				best_found_q  <= 1'b0;
				pinned_q      <= 1'b0;
				pfree_found_q <= 1'b0;
			end
			if (cmd.slot_rst) begin
				si_q <= '0;
			end
			if (cmd.slot_inc) begin
				si_q <= si_q + 1'b1;
			end
			if (cmd.pin_rst) begin
				pj_q     <= '0;
				pinned_q <= 1'b0;
			end
			if (cmd.pin_inc) begin
				pj_q <= pj_q + 1'b1;
			end
			if (cmd.find_cmp) begin
				if (valid_q[si_q] && key_rd == key_q && !found_q) begin
					found_q <= 1'b1;
				end
				if (!valid_q[si_q] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (cmd.pin_cmp_slot && pin_valid_q[pj_q] && pin_rd == key_rd) begin
				pinned_q <= 1'b1;
			end
			if (cmd.pin_cmp_key) begin
				if (pin_valid_q[pj_q] && pin_rd == key_q) begin
					pinned_q <= 1'b1;
				end
				if (!pin_valid_q[pj_q] && !pfree_found_q) begin
					pfree_found_q <= 1'b1;
				end
			end
			if (cmd.cand_eval && !pinned_q && (!best_found_q || used_rd < best_used_q)) begin
				best_found_q <= 1'b1;
			end
			if (cmd.write_entry) begin
				valid_q[target_slot] <= 1'b1;
			end
			if (cmd.write_entry || cmd.touch) begin
				tick_q <= tick_nx;
			end
			if (cmd.remove) begin
				valid_q[found_slot_q] <= 1'b0;
			end
			if (cmd.pins_clear) begin
				pin_valid_q <= '0;
			end
			if (cmd.pin_write) begin
				pin_valid_q[pfree_idx_q] <= 1'b1;
			end
			if (cmd.set_result) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: captured item, tracked slots and keys, result fields.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q      <= req_kind;
			key_q       <= req_key;
			status_q    <= STAT_OK;
			res_hit_q   <= 1'b0;
			res_slot_q  <= '0;
			res_ev_q    <= 1'b0;
			res_evkey_q <= '0;
		end
		if (cmd.find_cmp) begin
			if (valid_q[si_q] && key_rd == key_q && !found_q) begin
				found_slot_q <= si_q;
			end
			if (!valid_q[si_q] && !free_found_q) begin
				free_slot_q <= si_q;
			end
		end
		if (cmd.pin_cmp_key && !pin_valid_q[pj_q] && !pfree_found_q) begin
			pfree_idx_q <= pj_q;
		end
		if (cmd.cand_eval && !pinned_q && (!best_found_q || used_rd < best_used_q)) begin
			best_slot_q <= si_q;
			best_used_q <= used_rd;
			best_key_q  <= key_rd;
		end
		if (cmd.set_status) begin
			status_q <= cmd.res_status;
		end
		if (cmd.mark_hit) begin
			res_hit_q  <= 1'b1;
			res_slot_q <= found_slot_q;
		end
		if (cmd.write_entry) begin
			res_slot_q  <= target_slot;
			res_ev_q    <= cmd.use_best;
			res_evkey_q <= cmd.use_best ? best_key_q : '0;
		end
		if (cmd.set_result) begin
			rsp_status      <= status_q;
			rsp_hit         <= res_hit_q;
			rsp_slot        <= res_slot_q;
			rsp_evicted     <= res_ev_q;
			rsp_evicted_key <= res_evkey_q;
		end
	end

	assign rsp_valid = out_valid_q;

	a_tick_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q >= $past(tick_q))
		else $error("use tick went backwards");
	a_insert_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_entry |=> valid_q[$past(target_slot)])
		else $error("inserted slot not marked valid");
	a_pin_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pin_write |=> pin_valid_q[$past(pfree_idx_q)])
		else $error("added pin not marked valid");
endmodule

FILE: design/lru_slot_allocator_with_pinning.sv
// Top level of the LRU slot allocator with pinning: controller and datapath.
// Depends on lsa_pkg, lsa_if, lsa_ram, lsa_ctrl, lsa_dp.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, key
//   rsp      out  valid/ready    status, hit, slot, evicted, evicted_key
//   cfg      in   cfg_we         cfg_wdata (read_only)
//
// One item at a time. Lookup, touch, insert and remove (the last two unless read-only)
// scan all slots; an insert into a full table rescans them with a pin scan per slot
// for the pinned check, and pin add scans the pins; plus dispatch and result states.
// The scan length is set by the single read port of the key and tick memories.
// Reset clears all valid bits at once; the next item is taken while a result waits.
module lru_slot_allocator_with_pinning #(
	parameter int SLOTS = 64,
	parameter int PINS  = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	lsa_req_if.sink   req,
	lsa_rsp_if.source rsp
);
	import lsa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	lsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
		.stat(stat), .cmd(cmd)
	);

	lsa_dp #(.SLOTS(SLOTS), .PINS(PINS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_kind(req.kind), .req_key(req.key),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.status),
		.rsp_hit(rsp.hit), .rsp_slot(rsp.slot), .rsp_evicted(rsp.evicted),
		.rsp_evicted_key(rsp.evicted_key)
	);
endmodule
